FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/swvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swvr_pkg
// Types and constants shared by the stack controller, datapath and top level.
// ----------------------------------------------------------------------------
package swvr_pkg;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 9;
	localparam int DEPTH_DEF = 256;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    take;        // latch request operand
		logic    push_wr;     // write operand on top, count up
		logic    top_rd;      // read top entry
		logic    pop_dec;     // count down
		logic    scan_start;  // clear scan pointers
		logic    scan_step;   // compaction step
		logic    scan_end;    // count <= compacted count
		logic    out_load;    // load output register
		logic    out_sel_rd;  // result value from read data
		status_t out_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_idle;  // all entries read and compared
		logic out_free;   // output register can take a result
	} dp_stat_t;

endpackage

FILE: src/swvr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swvr_dp
// Stack datapath: entry memory, occupancy, compaction pointers, output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swvr_dp #(
	parameter int DEPTH = swvr_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swvr_pkg::cmd_t                    cmd,
	input  logic signed [swvr_pkg::DATA_W-1:0] operand_value,
	output swvr_pkg::dp_stat_t                stat,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swvr_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = swvr_pkg::DATA_W;
	localparam int NW = swvr_pkg::COUNT_W;
	localparam int PAD_W = swvr_pkg::M_TDATA_W - DW - 2 - NW;

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [DW-1:0] val_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          pend_q;

	logic          out_valid_q;
	logic [DW-1:0] out_value_q;
	swvr_pkg::status_t out_status_q;
	logic [NW-1:0] out_count_q;

	logic          scan_issue;
	logic          keep;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	assign scan_issue = cmd.scan_step && (rd_q != occ_q);
	// previous read returned a word that survives removal
	assign keep = cmd.scan_step && pend_q && (rdata_q != val_q);

	always_comb begin
		mem_we    = cmd.push_wr || keep;
		mem_waddr = cmd.push_wr ? occ_q[AW-1:0] : wr_q[AW-1:0];
		mem_wdata = cmd.push_wr ? operand_value : rdata_q;
		mem_re    = cmd.top_rd || scan_issue;
		mem_raddr = cmd.top_rd ? AW'(occ_q - 1'b1) : rd_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
		if (cmd.take) begin
			val_q <= operand_value;
		end
		if (cmd.out_load) begin
			out_value_q  <= cmd.out_sel_rd ? rdata_q : '0;
			out_status_q <= cmd.out_status;
			out_count_q  <= NW'(occ_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.pop_dec) begin
				occ_q <= occ_q - 1'b1;
			end else if (cmd.scan_end) begin
				occ_q <= wr_q;
			end

			if (cmd.scan_start) begin
				rd_q   <= '0;
				wr_q   <= '0;
				pend_q <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_q <= scan_issue;
				if (scan_issue) begin
					rd_q <= rd_q + 1'b1;
				end
				if (keep) begin
					wr_q <= wr_q + 1'b1;
				end
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.empty     = (occ_q == '0);
		stat.full      = (occ_q == CW'(DEPTH));
		stat.scan_idle = (rd_q == occ_q) && !pend_q;
		stat.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_count_q, out_status_q, out_value_q};

	`ASSERT_ALWAYS(a_occ_range, clk, arst_n, occ_q <= CW'(DEPTH), "occupancy above depth")
	`ASSERT_ALWAYS(a_wr_behind_rd, clk, arst_n, wr_q <= rd_q, "compaction write passed read")
	`ASSERT_IMPLIES(a_push_room, clk, arst_n, cmd.push_wr, occ_q != CW'(DEPTH),
		"push written to full stack")
	`ASSERT_IMPLIES(a_read_nonempty, clk, arst_n, cmd.top_rd, occ_q != '0,
		"top read on empty stack")

endmodule

FILE: src/swvr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swvr_ctrl
// Stack controller: decodes requests and sequences the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swvr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  swvr_pkg::op_t      opcode,
	input  swvr_pkg::dp_stat_t stat,
	output swvr_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t            state_q, state_d;
	logic              sel_rd_q, sel_rd_d;
	swvr_pkg::status_t res_q, res_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		sel_rd_d   = sel_rd_q;
		res_d      = res_q;
		cmd.out_sel_rd = sel_rd_q;
		cmd.out_status = res_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					sel_rd_d = 1'b0;
					res_d    = swvr_pkg::ST_OK;
					state_d  = S_FIN;
					case (opcode)
						swvr_pkg::OP_PUSH: begin
							if (stat.full) begin
								res_d = swvr_pkg::ST_FULL;
							end else begin
								cmd.push_wr = 1'b1;
							end
						end
						swvr_pkg::OP_POP, swvr_pkg::OP_PEEK: begin
							if (stat.empty) begin
								res_d = swvr_pkg::ST_EMPTY;
							end else begin
								cmd.top_rd  = 1'b1;
								cmd.pop_dec = (opcode == swvr_pkg::OP_POP);
								sel_rd_d    = 1'b1;
							end
						end
						default: begin
							if (stat.empty) begin
								res_d = swvr_pkg::ST_EMPTY;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_idle) begin
					cmd.scan_end = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_rd_q <= 1'b0;
			res_q    <= swvr_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			sel_rd_q <= sel_rd_d;
			res_q    <= res_d;
		end
	end

	`ASSERT_NEXT(a_load_idle, clk, arst_n, cmd.out_load, s_tready, "no return to idle after result")
	`ASSERT_NEXT(a_take_busy, clk, arst_n, cmd.take, !s_tready, "request taken without work")
	`ASSERT_IMPLIES(a_one_mem_write, clk, arst_n, cmd.push_wr, !cmd.scan_step,
		"push during compaction")

endmodule

FILE: src/stack_with_value_removal_top.sv
`timescale 1ns / 1ps
// A stack of DEPTH signed 32-bit words. Each request (push, pop, peek, remove all
// entries equal to a value) gives exactly one result with the entry count after the
// operation. Push, pop and peek go from the accept cycle to the result state,
// which loads once the output register is free; the accept cycle does the memory
// write or issues the registered memory read. Remove walks the entry memory one
// entry per cycle, reading the next entry while a kept one is written back. One
// request is in work at a time; a finished result waits in the output register
// while the next request is accepted. Entries need no clearing after reset.
// ----------------------------------------------------------------------------
// stack_with_value_removal_top
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module stack_with_value_removal_top #(
	parameter int DEPTH = swvr_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] opcode, [33:2] operand_value, [39:34] zero
	input  logic [swvr_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] result_value, [33:32] status, [42:34] entry_count, [47:43] zero
	output logic [swvr_pkg::M_TDATA_W-1:0]    m_tdata
);

	swvr_pkg::cmd_t     cmd;
	swvr_pkg::dp_stat_t stat;
	swvr_pkg::op_t      opcode;
	logic signed [swvr_pkg::DATA_W-1:0] operand_value;

	assign opcode        = swvr_pkg::op_t'(s_tdata[1:0]);
	assign operand_value = s_tdata[swvr_pkg::DATA_W+1:2];

	swvr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	swvr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operand_value (operand_value),
		.stat          (stat),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule
